// ----- hw/rtl/atds_pkg.sv -----
package atds_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int ACT_W  = 3;
  localparam int TIME_W = 27;
  localparam int DOSE_W = 8;
  localparam int STAT_W = 2;
  localparam int SLOT_W = 4;

  localparam int IN_FIELDS_W  = ACT_W + 2 * TIME_W + DOSE_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = STAT_W + SLOT_W + TIME_W + DOSE_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // 9999:59:59, marks "no timer pending"
  localparam logic [TIME_W-1:0] NO_TIMER_MARK = TIME_W'(99995959);

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD  = 3'd0,
    ACT_TAKE = 3'd1,
    ACT_NEXT = 3'd2,
    ACT_RSTF = 3'd3,
    ACT_CLR  = 3'd4
  } act_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_NONE = 2'd1,
    STAT_FULL = 2'd2
  } stat_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

endpackage

// ----- hw/rtl/alarm_table_due_search.sv -----
// channel | dir | tdata fields, lowest bit first
// --------+-----+-------------------------------------------------------------
// in_     | in  | action[2:0], alarm_time[29:3], now_time[56:30], dose_amount[64:57]
// out_    | out | status[1:0], slot_index[5:2], found_time[32:6], found_amount[40:33]
//
// add, reset-fired, clear-all and unused codes: result valid in the cycle after the beat.
// take-due and next-pending: one pass over the table through a single read port;
//   a take-due hit ends the pass early.
// one item at a time; in_tready is low while a pass runs or a result is stuck unread.
// reset clears the entry count and the sequencer; table contents are not cleared.
module alarm_table_due_search (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // action, alarm_time, now_time, dose_amount
  input  logic [atds_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // status, slot_index, found_time, found_amount
  output logic [atds_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import atds_pkg::*;

  // table storage
  logic [TIME_W-1:0] time_mem [TABLE_DEPTH];
  logic [DOSE_W-1:0] dose_mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] fired_r, fired_nxt;

  state_t             state_r, state_nxt;
  logic [ACT_W-1:0]   op_r, op_nxt;
  logic [TIME_W-1:0]  now_r, now_nxt;
  logic [TIME_W-1:0]  best_r, best_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   issue_r, issue_nxt;
  logic [IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [TIME_W-1:0]  rd_time_r;
  logic [DOSE_W-1:0]  rd_dose_r;

  logic               out_valid_r, out_valid_nxt;
  stat_t              out_stat_r, out_stat_nxt;
  logic [SLOT_W-1:0]  out_slot_r, out_slot_nxt;
  logic [TIME_W-1:0]  out_time_r, out_time_nxt;
  logic [DOSE_W-1:0]  out_dose_r, out_dose_nxt;

  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;

  logic [ACT_W-1:0]   in_action;
  logic [TIME_W-1:0]  in_alarm;
  logic [TIME_W-1:0]  in_now;
  logic [DOSE_W-1:0]  in_dose;
  logic               in_beat;
  logic               take_hit;
  logic               next_cand;
  logic               scan_end;

  assign in_action = in_tdata[ACT_W-1:0];
  assign in_alarm  = in_tdata[ACT_W+TIME_W-1:ACT_W];
  assign in_now    = in_tdata[ACT_W+2*TIME_W-1:ACT_W+TIME_W];
  assign in_dose   = in_tdata[IN_FIELDS_W-1:ACT_W+2*TIME_W];

  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_beat   = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - OUT_FIELDS_W)'(0),
                       out_dose_r, out_time_r, out_slot_r, out_stat_r};

  // compare logic, fed by the registered read of the previous cycle
  assign take_hit  = rd_vld_r && (op_r == ACT_TAKE) && !fired_r[rd_idx_r]
                     && (rd_time_r <= now_r);
  assign next_cand = rd_vld_r && (op_r == ACT_NEXT) && !fired_r[rd_idx_r]
                     && (rd_time_r <= best_r) && (now_r <= rd_time_r);
  assign scan_end  = (issue_r == count_r);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    now_nxt       = now_r;
    best_nxt      = best_r;
    count_nxt     = count_r;
    issue_nxt     = issue_r;
    rd_idx_nxt    = rd_idx_r;
    rd_vld_nxt    = 1'b0;
    fired_nxt     = fired_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_stat_nxt  = out_stat_r;
    out_slot_nxt  = out_slot_r;
    out_time_nxt  = out_time_r;
    out_dose_nxt  = out_dose_r;
    rd_en         = 1'b0;
    rd_addr       = issue_r[IDX_W-1:0];
    wr_en         = 1'b0;
    wr_addr       = count_r[IDX_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          op_nxt        = in_action;
          now_nxt       = in_now;
          best_nxt      = NO_TIMER_MARK;
          issue_nxt     = '0;
          out_valid_nxt = 1'b1;
          out_stat_nxt  = STAT_OK;
          out_slot_nxt  = '0;
          out_time_nxt  = '0;
          out_dose_nxt  = '0;
          unique case (in_action)
            ACT_ADD: begin
              if (count_r >= CNT_W'(TABLE_DEPTH)) begin
                out_stat_nxt = STAT_FULL;
              end else begin
                wr_en              = 1'b1;
                fired_nxt[wr_addr] = (in_now > in_alarm);
                out_slot_nxt       = SLOT_W'(count_r[IDX_W-1:0]);
                count_nxt          = count_r + 1'b1;
              end
            end
            ACT_TAKE, ACT_NEXT: begin
              out_valid_nxt = 1'b0;
              state_nxt     = ST_SCAN;
            end
            ACT_RSTF: fired_nxt = '0;
            ACT_CLR:  count_nxt = '0;
            default:  out_stat_nxt = STAT_NONE;
          endcase
        end
      end
      ST_SCAN: begin
        if (!scan_end) begin
          rd_en      = 1'b1;
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = issue_r[IDX_W-1:0];
          issue_nxt  = issue_r + 1'b1;
        end
        if (next_cand) begin
          best_nxt = rd_time_r;
        end
        priority if (take_hit) begin
          fired_nxt[rd_idx_r] = 1'b1;
          rd_vld_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_stat_nxt  = STAT_OK;
          out_slot_nxt  = SLOT_W'(rd_idx_r);
          out_time_nxt  = rd_time_r;
          out_dose_nxt  = rd_dose_r;
        end else if (scan_end) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_slot_nxt  = '0;
          out_dose_nxt  = '0;
          if ((op_r == ACT_NEXT) && (best_nxt != NO_TIMER_MARK)) begin
            out_stat_nxt = STAT_OK;
            out_time_nxt = best_nxt;
          end else begin
            out_stat_nxt = STAT_NONE;
            out_time_nxt = '0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    now_r      <= now_nxt;
    best_r     <= best_nxt;
    issue_r    <= issue_nxt;
    rd_idx_r   <= rd_idx_nxt;
    fired_r    <= fired_nxt;
    out_stat_r <= out_stat_nxt;
    out_slot_r <= out_slot_nxt;
    out_time_r <= out_time_nxt;
    out_dose_r <= out_dose_nxt;
  end

  // table memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      time_mem[wr_addr] <= in_alarm;
      dose_mem[wr_addr] <= in_dose;
    end
    if (rd_en) begin
      rd_time_r <= time_mem[rd_addr];
      rd_dose_r <= dose_mem[rd_addr];
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (issue_r <= count_r))
    else $error("scan index ran past entry count");

  a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == ST_SCAN))
    else $error("read data pending outside a scan");

  a_search_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && ((in_action == ACT_TAKE) || (in_action == ACT_NEXT)))
      |=> ((state_r == ST_SCAN) && !out_valid_r))
    else $error("search beat did not start a scan");

  a_scan_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SCAN) && (take_hit || scan_end)) |=> (out_valid_r && (state_r == ST_IDLE)))
    else $error("scan finished without a result");
`endif

endmodule

// ----- bench/alarm_table_due_search_tb.sv -----
module alarm_table_due_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import atds_pkg::*;

  localparam int SLOT_LO = STAT_W;
  localparam int TIME_LO = STAT_W + SLOT_W;
  localparam int DOSE_LO = TIME_LO + TIME_W;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef struct {
    logic [ACT_W-1:0]  action;
    logic [TIME_W-1:0] alarm_time;
    logic [TIME_W-1:0] now_time;
    logic [DOSE_W-1:0] dose;
    bit                wait_drain;
  } alarm_req_t;

  typedef struct {
    stat_t             status;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] found_time;
    logic [DOSE_W-1:0] amount;
  } alarm_rsp_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  alarm_req_t req_pending[$];
  alarm_rsp_t rsp_expected[$];
  alarm_req_t cur_req;

  // predictor copy of the alarm table
  logic [TIME_W-1:0] tbl_time [TABLE_DEPTH];
  bit                tbl_fired[TABLE_DEPTH];
  logic [DOSE_W-1:0] tbl_dose [TABLE_DEPTH];
  int                tbl_count = 0;

  // stimulus-side view of the table contents
  logic [TIME_W-1:0] gen_times[$];

  int req_total = 0;
  int req_accepted = 0;
  int rsp_checked = 0;
  int errors = 0;
  int n_taken = 0;
  int n_next_found = 0;
  int n_full = 0;
  int n_unused = 0;

  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  bit          sender_busy;

  int unsigned rx_cycles = 0;
  int unsigned rx_mode = 0;
  int unsigned rx_mode_left = 0;
  int unsigned hold_left = 0;

  alarm_table_due_search DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic alarm_rsp_t predict_alarm(alarm_req_t r);
    alarm_rsp_t        rsp;
    logic [TIME_W-1:0] best;
    bit                hit;
    int                i;
    rsp.status = STAT_OK;
    rsp.slot = '0;
    rsp.found_time = '0;
    rsp.amount = '0;
    case (r.action)
      ACT_ADD: begin
        if (tbl_count >= TABLE_DEPTH) begin
          rsp.status = STAT_FULL;
          n_full++;
        end else begin
          tbl_time[tbl_count] = r.alarm_time;
          // already in the past when added -> born fired
          tbl_fired[tbl_count] = (r.now_time > r.alarm_time);
          tbl_dose[tbl_count] = r.dose;
          rsp.slot = SLOT_W'(tbl_count);
          tbl_count++;
        end
      end
      ACT_TAKE: begin
        hit = 1'b0;
        for (i = 0; i < tbl_count; i++) begin
          if (!hit && !tbl_fired[i] && tbl_time[i] <= r.now_time) begin
            hit = 1'b1;
            tbl_fired[i] = 1'b1;
            rsp.slot = SLOT_W'(i);
            rsp.found_time = tbl_time[i];
            rsp.amount = tbl_dose[i];
          end
        end
        if (hit) n_taken++;
        else rsp.status = STAT_NONE;
      end
      ACT_NEXT: begin
        best = NO_TIMER_MARK;
        for (i = 0; i < tbl_count; i++) begin
          if (tbl_time[i] <= best && r.now_time <= tbl_time[i] && !tbl_fired[i])
            best = tbl_time[i];
        end
        // a best equal to the sentinel reads as nothing pending
        if (best == NO_TIMER_MARK) begin
          rsp.status = STAT_NONE;
        end else begin
          rsp.found_time = best;
          n_next_found++;
        end
      end
      ACT_RSTF: begin
        for (i = 0; i < TABLE_DEPTH; i++) tbl_fired[i] = 1'b0;
      end
      ACT_CLR: begin
        tbl_count = 0;
      end
      default: begin
        rsp.status = STAT_NONE;
        n_unused++;
      end
    endcase
    return rsp;
  endfunction

  task automatic queue_req(input logic [ACT_W-1:0] act, input logic [TIME_W-1:0] at,
                           input logic [TIME_W-1:0] now, input logic [DOSE_W-1:0] dose,
                           input bit drain);
    alarm_req_t r;
    r.action = act;
    r.alarm_time = at;
    r.now_time = now;
    r.dose = dose;
    r.wait_drain = drain;
    req_pending.insert(req_pending.size(), r);
    req_total++;
    if (act == ACT_ADD && gen_times.size() < TABLE_DEPTH) gen_times.insert(gen_times.size(), at);
    if (act == ACT_CLR) gen_times.delete();
  endtask

  function automatic logic [TIME_W-1:0] alarm_time_near(int unsigned base);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return NO_TIMER_MARK;
    if (r < 6) return TIME_W'($urandom_range(int'(NO_TIMER_MARK) + 1, int'(TIME_MAX)));
    if (r < 16) return TIME_W'($urandom_range(0, int'(NO_TIMER_MARK)));
    return TIME_W'(base + $urandom_range(0, 400));
  endfunction

  function automatic logic [TIME_W-1:0] now_near(int unsigned base);
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 10) return TIME_W'($urandom_range(0, int'(NO_TIMER_MARK)));
    if (r < 65 && gen_times.size() > 0) begin
      // hit an existing alarm time or step just before or past it
      v = int'(gen_times[$urandom_range(0, gen_times.size() - 1)]) + $urandom_range(0, 4) - 2;
      if (v < 0) v = 0;
      if (v > int'(TIME_MAX)) v = int'(TIME_MAX);
      return TIME_W'(v);
    end
    return TIME_W'(base + $urandom_range(0, 400));
  endfunction

  function automatic int unsigned new_base();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return int'(NO_TIMER_MARK) - 400;
    return $urandom_range(0, int'(NO_TIMER_MARK) - 400);
  endfunction

  // sender: bursts of beats with random gaps, holds the head item if it must wait for drain
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        rsp_expected.insert(rsp_expected.size(), predict_alarm(cur_req));
        req_accepted++;
      end
      sender_busy = in_tvalid && !in_tready;
      if (!sender_busy) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (req_pending.size() > 0 &&
                     !(req_pending[0].wait_drain && rsp_expected.size() > 0)) begin
          cur_req = req_pending.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= IN_TDATA_W'({cur_req.dose, cur_req.now_time, cur_req.alarm_time,
                                   cur_req.action});
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            case ($urandom_range(0, 9))
              0, 1: begin
                burst_left = $urandom_range(30, 60);
                gap_left = 0;
              end
              2: begin
                burst_left = $urandom_range(1, 8);
                gap_left = $urandom_range(10, 40);
              end
              default: begin
                burst_left = $urandom_range(1, 10);
                gap_left = $urandom_range(0, 4);
              end
            endcase
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: randomly chosen stall patterns, plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      rx_cycles++;
      if (rx_cycles == 600) hold_left = 400;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          rx_mode_left = $urandom_range(8, 80);
        end else begin
          rx_mode_left--;
        end
        case (rx_mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 1) == 1);
          2: out_tready <= ($urandom_range(0, 4) == 0);
          default: out_tready <= (rx_cycles[1:0] != 2'b00);
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    alarm_rsp_t exp_rsp;
    if (rst_n && out_tvalid && out_tready) begin
      if (rsp_expected.size() == 0) begin
        $display("%0t: result beat with nothing expected, got tdata %h", $time, out_tdata);
        errors++;
      end else begin
        exp_rsp = rsp_expected.pop_front();
        rsp_checked++;
        if (out_tdata[SLOT_LO-1:0] !== exp_rsp.status) begin
          $display("%0t: status mismatch: expected %0d, got %0d", $time, exp_rsp.status,
                   out_tdata[SLOT_LO-1:0]);
          errors++;
        end
        if (out_tdata[TIME_LO-1:SLOT_LO] !== exp_rsp.slot) begin
          $display("%0t: slot_index mismatch: expected %0d, got %0d", $time, exp_rsp.slot,
                   out_tdata[TIME_LO-1:SLOT_LO]);
          errors++;
        end
        if (out_tdata[DOSE_LO-1:TIME_LO] !== exp_rsp.found_time) begin
          $display("%0t: found_time mismatch: expected %0d, got %0d", $time,
                   exp_rsp.found_time, out_tdata[DOSE_LO-1:TIME_LO]);
          errors++;
        end
        if (out_tdata[DOSE_LO+DOSE_W-1:DOSE_LO] !== exp_rsp.amount) begin
          $display("%0t: found_amount mismatch: expected %0d, got %0d", $time,
                   exp_rsp.amount, out_tdata[DOSE_LO+DOSE_W-1:DOSE_LO]);
          errors++;
        end
      end
    end
  end

  initial begin
    int unsigned       n;
    int unsigned       pick;
    int unsigned       base;
    int unsigned       extra;
    bit                drain;
    logic [TIME_W-1:0] t;

    // directed: empty table, field extremes, sentinel and above-sentinel entries
    queue_req(ACT_NEXT, '0, '0, '0, 1'b0);
    queue_req(ACT_TAKE, '0, TIME_MAX, '0, 1'b0);
    queue_req(ACT_ADD, '0, '0, 8'h00, 1'b0);
    queue_req(ACT_ADD, NO_TIMER_MARK, '0, 8'hff, 1'b0);
    queue_req(ACT_ADD, TIME_MAX, '0, 8'haa, 1'b0);
    queue_req(ACT_ADD, TIME_W'(5000000), TIME_W'(6000000), 8'h55, 1'b0); // born fired
    queue_req(ACT_ADD, TIME_W'(12345678), TIME_W'(12345678), 8'h01, 1'b0); // now equals time
    queue_req(ACT_NEXT, TIME_MAX, '0, 8'hff, 1'b0);
    queue_req(ACT_NEXT, '0, TIME_W'(1), '0, 1'b0);
    queue_req(ACT_TAKE, '0, TIME_MAX, '0, 1'b0);
    queue_req(ACT_TAKE, '0, TIME_W'(12345677), '0, 1'b0);
    queue_req(ACT_TAKE, '0, TIME_W'(12345678), '0, 1'b0);
    // only the sentinel entry is left as candidate
    queue_req(ACT_NEXT, '0, TIME_W'(12345679), '0, 1'b0);
    queue_req(3'd5, TIME_MAX, TIME_MAX, 8'hff, 1'b0);
    queue_req(3'd6, TIME_MAX, TIME_MAX, 8'hff, 1'b0);
    queue_req(3'd7, '0, '0, '0, 1'b0);
    queue_req(ACT_RSTF, '0, '0, '0, 1'b0);
    queue_req(ACT_TAKE, '0, TIME_MAX, '0, 1'b0);
    queue_req(ACT_CLR, TIME_MAX, TIME_MAX, 8'hff, 1'b0);
    queue_req(ACT_NEXT, '0, '0, '0, 1'b0);

    // random: fill/take/next sequences around a time window, with noise mixed in
    base = new_base();
    for (n = 0; req_total < 400; n++) begin
      pick = $urandom_range(0, 99);
      drain = (n == 0) || (n % 150 == 149);
      if (pick < 4) begin
        extra = $urandom_range(1, 2);
        while (gen_times.size() < TABLE_DEPTH || extra > 0) begin
          if (gen_times.size() == TABLE_DEPTH) extra--;
          queue_req(ACT_ADD, alarm_time_near(base), now_near(base), 8'($urandom), drain);
          drain = 1'b0;
        end
      end else if (gen_times.size() == TABLE_DEPTH && pick < 25) begin
        queue_req(ACT_CLR, TIME_W'($urandom), TIME_W'($urandom), 8'($urandom), drain);
        base = new_base();
      end else if (pick < 42) begin
        t = alarm_time_near(base);
        queue_req(ACT_ADD, t, ($urandom_range(0, 1) == 1) ? t : now_near(base),
                  8'($urandom), drain);
      end else if (pick < 64) begin
        queue_req(ACT_TAKE, TIME_W'($urandom), now_near(base), 8'($urandom), drain);
      end else if (pick < 84) begin
        queue_req(ACT_NEXT, TIME_W'($urandom), now_near(base), 8'($urandom), drain);
      end else if (pick < 90) begin
        queue_req(ACT_RSTF, TIME_W'($urandom), TIME_W'($urandom), 8'($urandom), drain);
      end else if (pick < 94) begin
        queue_req(ACT_CLR, TIME_W'($urandom), TIME_W'($urandom), 8'($urandom), drain);
        base = new_base();
      end else begin
        queue_req(3'($urandom_range(5, 7)), TIME_W'($urandom), TIME_W'($urandom),
                  8'($urandom), drain);
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (req_accepted < req_total) @(negedge clk);
    while (rsp_expected.size() > 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("covered %0d requests: %0d due alarms taken, %0d pending times found,",
             req_total, n_taken, n_next_found);
    $display("%0d adds to a full table, %0d unused codes; %0d results checked, %0d errors",
             n_full, n_unused, rsp_checked, errors);
    if (errors == 0 && rsp_expected.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d of %0d requests accepted", req_accepted, req_total);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- alarm_table_due_search.f -----
hw/rtl/atds_pkg.sv
hw/rtl/alarm_table_due_search.sv
bench/alarm_table_due_search_tb.sv
